FILE: hdl/sparse_triplet_merge_add_macros.svh
// Assertion macros shared by the sparse triplet merge-add modules.
`ifndef SPARSE_TRIPLET_MERGE_ADD_MACROS_SVH
`define SPARSE_TRIPLET_MERGE_ADD_MACROS_SVH

// Checks that cons holds in the same cycle as ante, outside reset.
`define STMA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stma assertion failed");

// Checks that cons holds in the cycle after ante, outside reset.
`define STMA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stma assertion failed");

`endif

FILE: hdl/stma_pkg.sv
// Shared constants, codes and controller/datapath interface types.
`timescale 1ns / 1ps
package stma_pkg;

  // Default capacity of each coordinate list.
  localparam int MAX_ENTRIES_DEF = 16;

  // Field widths fixed by the interface.
  localparam int OP_W    = 2;
  localparam int IDX_W   = 8;
  localparam int VAL_W   = 16;
  localparam int SUM_W   = 17;
  localparam int DIM_W   = 9;
  localparam int ST_W    = 2;
  localparam int CIDX_W  = 2;
  localparam int ENTRY_W = 2 * IDX_W + VAL_W;

  // Request opcodes.
  localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_DIM   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] REG_ROWS_A = 2'd0;
  localparam logic [CIDX_W-1:0] REG_COLS_A = 2'd1;
  localparam logic [CIDX_W-1:0] REG_ROWS_B = 2'd2;
  localparam logic [CIDX_W-1:0] REG_COLS_B = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_a;
    logic            load_b;
    logic            start;
    logic            fetch;
    logic            emit_merge;
    logic            emit_special;
    logic            clear_counts;
    logic [ST_W-1:0] code;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dims_eq;
    logic lists_empty;
    logic merge_last;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/sparse_triplet_merge_add.sv
// Top level of the sparse coordinate-list merge-add block.
`timescale 1ns / 1ps
// Sparse matrix addition over two coordinate lists. Requests with opcode 0 or 1
// append one (row, col, value) entry to list A or B; an append to a full list is
// dropped. A start request (opcode 2) merges both lists in key order, summing
// entries at equal coordinates into a 17-bit value, and sends one result per
// coordinate with out_last on the final one. The start resets the merge indexes;
// then each result takes a read of the list heads from the single read port of
// each store and a compare that loads the output register, which waits while the
// output is stalled. Mismatched dimensions or two empty lists give a single status
// result instead. Both lists are emptied after every start. Configuration writes
// are always taken.
module sparse_triplet_merge_add
  import stma_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OP_W-1:0]         in_opcode,
  input  logic [IDX_W-1:0]        in_row,
  input  logic [IDX_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [SUM_W-1:0] out_value,
  output logic                    out_last,
  output logic [ST_W-1:0]         out_status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [DIM_W-1:0]        cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  stma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_opcode),
    .sts       (sts),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  // Stores, merge logic and output register.
  stma_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_row     (in_row),
    .in_col     (in_col),
    .in_value   (in_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_row    (out_row),
    .out_col    (out_col),
    .out_value  (out_value),
    .out_last   (out_last),
    .out_status (out_status)
  );

endmodule

FILE: hdl/stma_ctrl.sv
// Controller state machine that sequences loads, merges and special results.
`timescale 1ns / 1ps
module stma_ctrl
  import stma_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic [OP_W-1:0] in_opcode,
  input  sts_t            sts,
  output logic            in_stall,
  output cmd_t            cmd
);

`include "sparse_triplet_merge_add_macros.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_FETCH = 2'd1;
  localparam logic [1:0] S_COMP  = 2'd2;
  localparam logic [1:0] S_SPEC  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [ST_W-1:0] code_r, code_nxt;

  // Next state and command decode.
  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    cmd       = '0;
    cmd.code  = code_r;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_opcode)
            OP_LOAD_A: cmd.load_a = 1'b1;
            OP_LOAD_B: cmd.load_b = 1'b1;
            OP_START: begin
              if (!sts.dims_eq) begin
                code_nxt  = ST_DIM;
                state_nxt = S_SPEC;
              end else if (sts.lists_empty) begin
                code_nxt  = ST_EMPTY;
                state_nxt = S_SPEC;
              end else begin
                cmd.start = 1'b1;
                state_nxt = S_FETCH;
              end
            end
            default: ;
          endcase
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_COMP;
      end
      S_COMP: begin
        if (sts.out_free) begin
          cmd.emit_merge = 1'b1;
          if (sts.merge_last) begin
            cmd.clear_counts = 1'b1;
            state_nxt        = S_IDLE;
          end else begin
            state_nxt = S_FETCH;
          end
        end
      end
      S_SPEC: begin
        if (sts.out_free) begin
          cmd.emit_special = 1'b1;
          cmd.clear_counts = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_OK;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  // A result is only loaded into a free output register.
  `STMA_ASSERT_SAME(a_emit_free, cmd.emit_merge || cmd.emit_special, sts.out_free)
  // Merge and special results never collide.
  `STMA_ASSERT_SAME(a_emit_excl, cmd.emit_merge, !cmd.emit_special)
  // A fetch is always followed by a compare.
  `STMA_ASSERT_NEXT(a_fetch_comp, cmd.fetch, state_r == S_COMP)

endmodule

FILE: hdl/stma_dp.sv
// Datapath: list stores, counters, configuration, merge compare and output register.
`timescale 1ns / 1ps
module stma_dp
  import stma_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [IDX_W-1:0]        in_row,
  input  logic [IDX_W-1:0]        in_col,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CIDX_W-1:0]       cfg_index,
  input  logic [DIM_W-1:0]        cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [IDX_W-1:0]        out_row,
  output logic [IDX_W-1:0]        out_col,
  output logic signed [SUM_W-1:0] out_value,
  output logic                    out_last,
  output logic [ST_W-1:0]         out_status
);

`include "sparse_triplet_merge_add_macros.svh"

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int KW = 2 * IDX_W;

  logic [ENTRY_W-1:0] mem_a [MAX_ENTRIES];
  logic [ENTRY_W-1:0] mem_b [MAX_ENTRIES];
  logic [ENTRY_W-1:0] a_q_r, b_q_r;

  logic [CW-1:0] count_a_r, count_b_r, i_r, j_r, i_nxt, j_nxt;
  logic [DIM_W-1:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r;

  logic                    out_valid_r;
  logic [IDX_W-1:0]        out_row_r, out_col_r;
  logic signed [SUM_W-1:0] out_value_r;
  logic                    out_last_r;
  logic [ST_W-1:0]         out_status_r;

  logic                    a_full, b_full, a_avail, b_avail;
  logic                    sel_a, sel_b;
  logic [KW-1:0]           key_a, key_b, merge_key;
  logic signed [SUM_W-1:0] val_a, val_b, merge_val;
  logic [ENTRY_W-1:0]      in_entry;
  logic                    cfg_wr;

  assign in_entry  = {in_row, in_col, in_value};
  assign a_full    = (count_a_r == CW'(MAX_ENTRIES));
  assign b_full    = (count_b_r == CW'(MAX_ENTRIES));
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // List stores: one write at the fill count, one registered read per store.
  always_ff @(posedge clk) begin
    if (cmd.load_a && !a_full) begin
      mem_a[count_a_r[IW-1:0]] <= in_entry;
    end
    if (cmd.load_b && !b_full) begin
      mem_b[count_b_r[IW-1:0]] <= in_entry;
    end
    if (cmd.fetch) begin
      a_q_r <= mem_a[i_r[IW-1:0]];
      b_q_r <= mem_b[j_r[IW-1:0]];
    end
  end

  // Merge compare on the two fetched heads.
  always_comb begin
    a_avail = (i_r < count_a_r);
    b_avail = (j_r < count_b_r);
    key_a   = a_q_r[ENTRY_W-1 -: KW];
    key_b   = b_q_r[ENTRY_W-1 -: KW];
    val_a   = {a_q_r[VAL_W-1], a_q_r[VAL_W-1:0]};
    val_b   = {b_q_r[VAL_W-1], b_q_r[VAL_W-1:0]};
    sel_a   = !b_avail || (a_avail && (key_a < key_b));
    sel_b   = !sel_a && (!a_avail || (key_a > key_b));
    if (sel_a) begin
      merge_key = key_a;
      merge_val = val_a;
      i_nxt     = i_r + CW'(1);
      j_nxt     = j_r;
    end else if (sel_b) begin
      merge_key = key_b;
      merge_val = val_b;
      i_nxt     = i_r;
      j_nxt     = j_r + CW'(1);
    end else begin
      merge_key = key_a;
      merge_val = val_a + val_b;
      i_nxt     = i_r + CW'(1);
      j_nxt     = j_r + CW'(1);
    end
  end

  // Status towards the controller.
  always_comb begin
    sts.dims_eq     = (rows_a_r == rows_b_r) && (cols_a_r == cols_b_r);
    sts.lists_empty = (count_a_r == '0) && (count_b_r == '0);
    sts.merge_last  = (i_nxt >= count_a_r) && (j_nxt >= count_b_r);
    sts.out_free    = !out_valid_r || !out_stall;
  end

  // Fill counts and merge indexes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_a_r <= '0;
      count_b_r <= '0;
      i_r       <= '0;
      j_r       <= '0;
    end else begin
      if (cmd.clear_counts) begin
        count_a_r <= '0;
        count_b_r <= '0;
      end else begin
        if (cmd.load_a && !a_full) begin
          count_a_r <= count_a_r + CW'(1);
        end
        if (cmd.load_b && !b_full) begin
          count_b_r <= count_b_r + CW'(1);
        end
      end
      if (cmd.start || cmd.clear_counts) begin
        i_r <= '0;
        j_r <= '0;
      end else if (cmd.emit_merge) begin
        i_r <= i_nxt;
        j_r <= j_nxt;
      end
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= DIM_W'(1);
      cols_a_r <= DIM_W'(1);
      rows_b_r <= DIM_W'(1);
      cols_b_r <= DIM_W'(1);
    end else if (cfg_wr) begin
      case (cfg_index)
        REG_ROWS_A: rows_a_r <= cfg_data;
        REG_COLS_A: cols_a_r <= cfg_data;
        REG_ROWS_B: rows_b_r <= cfg_data;
        REG_COLS_B: cols_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_merge || cmd.emit_special) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (cmd.emit_merge) begin
      out_row_r    <= merge_key[KW-1 -: IDX_W];
      out_col_r    <= merge_key[IDX_W-1:0];
      out_value_r  <= merge_val;
      out_last_r   <= sts.merge_last;
      out_status_r <= ST_OK;
    end else if (cmd.emit_special) begin
      out_row_r    <= '0;
      out_col_r    <= '0;
      out_value_r  <= '0;
      out_last_r   <= 1'b1;
      out_status_r <= cmd.code;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_row    = out_row_r;
  assign out_col    = out_col_r;
  assign out_value  = out_value_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  // A merge step always has at least one list entry left.
  `STMA_ASSERT_SAME(a_merge_left, cmd.emit_merge, a_avail || b_avail)
  // The merge indexes never run past the fill counts.
  `STMA_ASSERT_SAME(a_idx_bound, 1'b1, (i_r <= count_a_r) && (j_r <= count_b_r))

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the sparse coordinate-list merge-add block.
`timescale 1ns / 1ps
module tb;
  import stma_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int KEY_W          = 2 * IDX_W;
  localparam int HALF_PERIOD_NS = 6;
  localparam int TARGET_ITEMS   = 370;
  localparam int QUIET_ITEMS    = 60;
  localparam int LONG_HOLD      = 200;
  localparam int DRAIN_PAD      = 8;
  localparam int WATCHDOG_LIMIT = 3000;

  // One stored list entry and one merged result.
  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } coord_entry_t;

  typedef struct packed {
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [SUM_W-1:0] value;
    logic                    last;
    logic [ST_W-1:0]         status;
  } sum_entry_t;

  // Keeps its own copy of both lists and the dimensions, and predicts the
  // results of every accepted request.
  class merge_add_scoreboard;
    coord_entry_t            list_a [MAX_ENTRIES_DEF];
    coord_entry_t            list_b [MAX_ENTRIES_DEF];
    int unsigned             fill_a;
    int unsigned             fill_b;
    logic [DIM_W-1:0]        dims [4];
    sum_entry_t              expected_sums [$];
    int unsigned             mismatches;
    int unsigned             checked;
    int unsigned             merges;
    int unsigned             dim_errors;
    int unsigned             empty_sums;

    function new();
      fill_a = 0;
      fill_b = 0;
      foreach (dims[n]) dims[n] = DIM_W'(1);
      mismatches = 0;
      checked = 0;
      merges = 0;
      dim_errors = 0;
      empty_sums = 0;
    endfunction

    function void write_dim(logic [CIDX_W-1:0] idx, logic [DIM_W-1:0] data);
      dims[idx] = data;
    endfunction

    function int unsigned pending();
      return expected_sums.size();
    endfunction

    function void push_status(logic [ST_W-1:0] code);
      sum_entry_t r;
      r = '0;
      r.last = 1'b1;
      r.status = code;
      expected_sums.push_back(r);
    endfunction

    // Appends go to the lists; a start walks both lists in key order.
    function void note_request(logic [OP_W-1:0] op, logic [IDX_W-1:0] row,
                               logic [IDX_W-1:0] col, logic signed [VAL_W-1:0] value);
      coord_entry_t e;
      sum_entry_t   r;
      int unsigned  ia;
      int unsigned  ib;
      logic [KEY_W-1:0] ka;
      logic [KEY_W-1:0] kb;
      e.row = row;
      e.col = col;
      e.value = value;
      case (op)
        OP_LOAD_A: begin
          if (fill_a < MAX_ENTRIES_DEF) begin
            list_a[fill_a] = e;
            fill_a++;
          end
        end
        OP_LOAD_B: begin
          if (fill_b < MAX_ENTRIES_DEF) begin
            list_b[fill_b] = e;
            fill_b++;
          end
        end
        OP_START: begin
          merges++;
          if (dims[REG_ROWS_A] != dims[REG_ROWS_B] || dims[REG_COLS_A] != dims[REG_COLS_B]) begin
            push_status(ST_DIM);
            dim_errors++;
          end else if (fill_a == 0 && fill_b == 0) begin
            push_status(ST_EMPTY);
            empty_sums++;
          end else begin
            ia = 0;
            ib = 0;
            ka = '0;
            kb = '0;
            while (ia < fill_a || ib < fill_b) begin
              if (ia < fill_a) ka = {list_a[ia].row, list_a[ia].col};
              if (ib < fill_b) kb = {list_b[ib].row, list_b[ib].col};
              if (ib >= fill_b || (ia < fill_a && ka < kb)) begin
                r.row = list_a[ia].row;
                r.col = list_a[ia].col;
                r.value = $signed(list_a[ia].value);
                ia++;
              end else if (ia >= fill_a || ka > kb) begin
                r.row = list_b[ib].row;
                r.col = list_b[ib].col;
                r.value = $signed(list_b[ib].value);
                ib++;
              end else begin
                r.row = list_a[ia].row;
                r.col = list_a[ia].col;
                r.value = $signed(list_a[ia].value) + $signed(list_b[ib].value);
                ia++;
                ib++;
              end
              r.last = (ia >= fill_a && ib >= fill_b);
              r.status = ST_OK;
              expected_sums.push_back(r);
            end
          end
          // Both lists are emptied whatever the start produced.
          fill_a = 0;
          fill_b = 0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string what);
      mismatches++;
      $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Compares one accepted result with the oldest prediction.
    task check_result(sum_entry_t got);
      sum_entry_t want;
      if (expected_sums.size() == 0) begin
        report_mismatch($sformatf("unexpected result row %0d col %0d value %0d status %0d",
                                  got.row, got.col, got.value, got.status));
      end else begin
        want = expected_sums.pop_front();
        checked++;
        if (got.row != want.row)
          report_mismatch($sformatf("row %0d, expected %0d", got.row, want.row));
        if (got.col != want.col)
          report_mismatch($sformatf("col %0d, expected %0d", got.col, want.col));
        if (got.value != want.value)
          report_mismatch($sformatf("value %0d, expected %0d", got.value, want.value));
        if (got.last != want.last)
          report_mismatch($sformatf("last %0b, expected %0b", got.last, want.last));
        if (got.status != want.status)
          report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      end
    endtask
  endclass

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [OP_W-1:0]         in_opcode = OP_LOAD_A;
  logic [IDX_W-1:0]        in_row = '0;
  logic [IDX_W-1:0]        in_col = '0;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [IDX_W-1:0]        out_row;
  logic [IDX_W-1:0]        out_col;
  logic signed [SUM_W-1:0] out_value;
  logic                    out_last;
  logic [ST_W-1:0]         out_status;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  logic [CIDX_W-1:0]       cfg_index = REG_ROWS_A;
  logic [DIM_W-1:0]        cfg_data = '0;

  merge_add_scoreboard sb = new();
  bit          send_idle = 1'b1;
  bit          recv_idle = 1'b1;
  bit          quiet_tail = 1'b0;
  bit          hold_request = 1'b0;
  int unsigned sent_items = 0;
  int unsigned long_holds = 0;

  sparse_triplet_merge_add dut (.*);

  always #(HALF_PERIOD_NS) clk = ~clk;

  // Result side: stall in random bursts, or for one long stretch on request.
  initial begin : result_stall_driver
    int unsigned burst;
    forever begin
      if (hold_request) begin
        out_stall <= 1'b1;
        hold_request = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_holds++;
      end else if (recv_idle && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        burst = $urandom_range(1, 11);
        repeat (burst) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  // Every accepted result is checked against the prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(sum_entry_t'{out_row, out_col, out_value, out_last, out_status});
  end

  // Ends the run when nothing has been accepted for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: no request accepted for %0d cycles.", WATCHDOG_LIMIT);
    $display("sparse_triplet_merge_add regression: fail");
    $finish;
  end

  // Offers one request, with an optional gap first, and waits until it is taken.
  task automatic send_request(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col,
                              input logic signed [VAL_W-1:0] value);
    int unsigned gap;
    if (send_idle && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 11);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_row <= row;
    in_col <= col;
    in_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, row, col, value);
    if (op != OP_UNUSED) sent_items++;
  endtask

  // Stops offering requests and waits until every predicted result is in.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Writes all four dimension registers; only called while the block is idle.
  task automatic set_dims(input int unsigned ra, input int unsigned ca,
                          input int unsigned rb, input int unsigned cb);
    logic [CIDX_W-1:0] regs [4];
    int unsigned       vals [4];
    regs = '{REG_ROWS_A, REG_COLS_A, REG_ROWS_B, REG_COLS_B};
    vals = '{ra, ca, rb, cb};
    foreach (regs[n]) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[n];
      cfg_data <= DIM_W'(vals[n]);
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_dim(regs[n], DIM_W'(vals[n]));
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // One random set of appends followed by a start. Most sets are two sorted
  // lists with shared coordinates; the rest are unsorted, overfilled or noise.
  task automatic send_merge_set();
    logic [KEY_W-1:0]        keys_a [$];
    logic [KEY_W-1:0]        keys_b [$];
    logic signed [VAL_W-1:0] vals_a [$];
    logic signed [VAL_W-1:0] vals_b [$];
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] va;
    int unsigned             flavour;
    int unsigned             n_keys;
    int unsigned             step_max;
    int unsigned             membership;
    if (!quiet_tail) begin
      send_idle = ($urandom_range(0, 2) != 0);
      recv_idle = ($urandom_range(0, 2) != 0);
    end
    flavour = $urandom_range(0, 9);
    if (flavour == 0) begin
      // Noise: arbitrary requests, the unused opcode among them.
      n_keys = $urandom_range(1, 8);
      repeat (n_keys)
        send_request(OP_W'($urandom_range(0, 3)), IDX_W'($urandom), IDX_W'($urandom),
                     VAL_W'($urandom));
    end else if (flavour == 1) begin
      // Unsorted lists with fully random coordinates.
      n_keys = $urandom_range(1, 6);
      repeat (n_keys) begin
        keys_a.push_back(KEY_W'($urandom));
        vals_a.push_back(pick_value());
      end
      n_keys = $urandom_range(1, 6);
      repeat (n_keys) begin
        keys_b.push_back(KEY_W'($urandom));
        vals_b.push_back(pick_value());
      end
    end else begin
      // Ascending keys; flavour 2 fills both lists to or past their capacity.
      if (flavour == 2)
        n_keys = $urandom_range(MAX_ENTRIES_DEF, MAX_ENTRIES_DEF + 3);
      else if ($urandom_range(0, 4) == 0)
        n_keys = $urandom_range(7, MAX_ENTRIES_DEF);
      else
        n_keys = $urandom_range(0, 6);
      step_max = ($urandom_range(0, 1) != 0) ? 3 : 3000;
      key = KEY_W'($urandom_range(0, 65535 - n_keys * step_max));
      repeat (n_keys) begin
        va = pick_value();
        membership = (flavour == 2) ? 2 : $urandom_range(0, 2);
        if (membership != 1) begin
          keys_a.push_back(key);
          vals_a.push_back(va);
        end
        if (membership != 0) begin
          keys_b.push_back(key);
          vals_b.push_back(($urandom_range(0, 3) == 0) ? -va : pick_value());
        end
        key = key + KEY_W'($urandom_range(1, step_max));
      end
    end
    // Interleave the two lists at random, keeping each list in order.
    while (keys_a.size() != 0 || keys_b.size() != 0) begin
      if (keys_b.size() == 0 || (keys_a.size() != 0 && $urandom_range(0, 1) == 0)) begin
        key = keys_a.pop_front();
        va = vals_a.pop_front();
        send_request(OP_LOAD_A, key[KEY_W-1:IDX_W], key[IDX_W-1:0], va);
      end else begin
        key = keys_b.pop_front();
        va = vals_b.pop_front();
        send_request(OP_LOAD_B, key[KEY_W-1:IDX_W], key[IDX_W-1:0], va);
      end
    end
    if (flavour != 0 || $urandom_range(0, 1) != 0)
      send_request(OP_START, IDX_W'($urandom), IDX_W'($urandom), VAL_W'($urandom));
  endtask

  task automatic run_random_until(input int unsigned item_mark);
    while (sent_items < item_mark) send_merge_set();
  endtask

  initial begin : main_sequence
    int unsigned side;
    int unsigned span;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset dimensions: empty sum, unused opcode,
    // extreme coordinates and values, a zero value, a cancelling sum,
    // single-list merges and an unsorted pair of lists.
    send_request(OP_START, 8'h00, 8'h00, 16'sh0000);
    send_request(OP_UNUSED, 8'hFF, 8'hFF, 16'sh7FFF);
    send_request(OP_LOAD_A, 8'h00, 8'h00, 16'sh7FFF);
    send_request(OP_LOAD_B, 8'h00, 8'h00, 16'sh7FFF);
    send_request(OP_LOAD_A, 8'h00, 8'h05, 16'sh8000);
    send_request(OP_LOAD_B, 8'h00, 8'h05, 16'sh8000);
    send_request(OP_LOAD_B, 8'h03, 8'h03, 16'sh0000);
    send_request(OP_LOAD_A, 8'hFF, 8'hFF, 16'sh0001);
    send_request(OP_LOAD_B, 8'hFF, 8'hFF, -16'sd1);
    send_request(OP_START, 8'hAA, 8'h55, 16'sh5A5A);
    send_request(OP_LOAD_A, 8'h07, 8'h09, 16'sd100);
    send_request(OP_START, 8'h00, 8'h00, 16'sh0000);
    send_request(OP_LOAD_B, 8'h01, 8'h02, -16'sd5);
    send_request(OP_START, 8'h00, 8'h00, 16'sh0000);
    send_request(OP_LOAD_A, 8'h05, 8'h05, 16'sd1);
    send_request(OP_LOAD_A, 8'h02, 8'h02, 16'sd2);
    send_request(OP_LOAD_B, 8'h03, 8'h03, 16'sd3);
    send_request(OP_START, 8'h00, 8'h00, 16'sh0000);
    drain_results();

    // Largest matching dimensions.
    set_dims(256, 256, 256, 256);
    run_random_until(130);
    drain_results();

    // Column mismatch: every start reports an error and still empties the lists.
    set_dims(256, 256, 256, 255);
    send_request(OP_LOAD_A, 8'h10, 8'h20, 16'sd7);
    send_request(OP_LOAD_B, 8'h10, 8'h20, 16'sd9);
    send_request(OP_START, 8'h00, 8'h00, 16'sh0000);
    run_random_until(160);
    drain_results();

    // Row mismatch.
    set_dims(1, 256, 2, 256);
    run_random_until(190);
    drain_results();

    // Smallest dimensions; the first start finds both lists empty. A long
    // result stall then lets the block back up onto its input.
    set_dims(1, 1, 1, 1);
    send_request(OP_START, 8'h00, 8'h00, 16'sh0000);
    hold_request = 1'b1;
    run_random_until(250);
    drain_results();

    // Random matching dimensions, then a tail with no idling on either side.
    side = $urandom_range(1, 256);
    span = $urandom_range(1, 256);
    set_dims(side, span, side, span);
    run_random_until(TARGET_ITEMS - QUIET_ITEMS);
    quiet_tail = 1'b1;
    send_idle = 1'b0;
    recv_idle = 1'b0;
    run_random_until(TARGET_ITEMS);
    drain_results();

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    $display("Ran %0d requests through %0d starts; %0d results checked.",
             sent_items, sb.merges, sb.checked);
    $display("Starts with dimension errors: %0d, empty sums: %0d, long stalls: %0d.",
             sb.dim_errors, sb.empty_sums, long_holds);
    if (sb.mismatches == 0)
      $display("sparse_triplet_merge_add regression: pass");
    else
      $display("sparse_triplet_merge_add regression: fail");
    $finish;
  end

endmodule
